FILE: rtl/smh_pkg.sv
// Shared types, constants and command/status structs for the SHA-256 message hasher.
package smh_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BLOCK_WDS = 16;
    localparam int unsigned DIGEST_WDS = 8;
    localparam int unsigned ROUNDS    = 64;
    localparam int unsigned LEN_W     = 61;

    typedef struct packed {
        logic [31:0] msg_word;
        logic [2:0]  valid_bytes;
        logic        last_item;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        digest_last;
    } out_item_t;

    // Source of a word pushed into the block buffer.
    typedef enum logic [2:0] {
        SRC_INPUT  = 3'd0,
        SRC_HELD   = 3'd1,
        SRC_PAD    = 3'd2,
        SRC_ZERO   = 3'd3,
        SRC_LEN_HI = 3'd4,
        SRC_LEN_LO = 3'd5
    } push_src_t;

    typedef struct packed {
        logic      accept;
        logic      push;
        push_src_t src;
        logic      comp_init;
        logic      round;
        logic      finalize;
        logic      emit;
        logic [2:0] emit_idx;
        logic      rearm;
    } dp_cmd_t;

    typedef struct packed {
        logic pos_last;
        logic pos_len;
        logic round_done;
        logic out_free;
    } dp_status_t;

    localparam logic [0:7][31:0] IV = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] K_TABLE = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

FILE: rtl/smh_ctrl.sv
// Sequencing state machine: message intake, padding, compression and digest output.
module smh_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  smh_pkg::in_item_t   s_data,
    output logic                s_ready,
    input  smh_pkg::dp_status_t status,
    output smh_pkg::dp_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_PAD_MSG  = 8'b0000_0010,
        ST_PAD_MARK = 8'b0000_0100,
        ST_PAD_ZERO = 8'b0000_1000,
        ST_LEN_HI   = 8'b0001_0000,
        ST_LEN_LO   = 8'b0010_0000,
        ST_COMP     = 8'b0100_0000,
        ST_OUT      = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [2:0] idx_reg, idx_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.src    = smh_pkg::SRC_ZERO;
        cmd.emit_idx = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (!s_data.last_item) begin
                        cmd.push = 1'b1;
                        cmd.src  = smh_pkg::SRC_INPUT;
                        if (status.pos_last) begin
                            cmd.comp_init = 1'b1;
                            ret_next      = ST_IDLE;
                            state_next    = ST_COMP;
                        end
                    end else if (s_data.valid_bytes inside {[3'd4:3'd7]}) begin
                        state_next = ST_PAD_MSG;
                    end else begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MSG: begin
                cmd.push = 1'b1;
                cmd.src  = smh_pkg::SRC_HELD;
                if (status.pos_last) begin
                    cmd.comp_init = 1'b1;
                    ret_next      = ST_PAD_MARK;
                    state_next    = ST_COMP;
                end else begin
                    state_next = ST_PAD_MARK;
                end
            end
            ST_PAD_MARK: begin
                cmd.push = 1'b1;
                cmd.src  = smh_pkg::SRC_PAD;
                if (status.pos_last) begin
                    cmd.comp_init = 1'b1;
                    ret_next      = ST_PAD_ZERO;
                    state_next    = ST_COMP;
                end else begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO: begin
                // Fill with zeros up to the two length slots, wrapping a block if needed.
                if (status.pos_len) begin
                    state_next = ST_LEN_HI;
                end else begin
                    cmd.push = 1'b1;
                    cmd.src  = smh_pkg::SRC_ZERO;
                    if (status.pos_last) begin
                        cmd.comp_init = 1'b1;
                        ret_next      = ST_PAD_ZERO;
                        state_next    = ST_COMP;
                    end
                end
            end
            ST_LEN_HI: begin
                cmd.push   = 1'b1;
                cmd.src    = smh_pkg::SRC_LEN_HI;
                state_next = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                cmd.push      = 1'b1;
                cmd.src       = smh_pkg::SRC_LEN_LO;
                cmd.comp_init = 1'b1;
                ret_next      = ST_OUT;
                state_next    = ST_COMP;
            end
            ST_COMP: begin
                if (status.round_done) begin
                    cmd.finalize = 1'b1;
                    state_next   = ret_reg;
                end else begin
                    cmd.round = 1'b1;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (idx_reg == 3'd7) begin
                        cmd.rearm  = 1'b1;
                        idx_next   = 3'd0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            idx_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            idx_reg   <= idx_next;
        end
    end

    a_init_enters_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.comp_init |=> state_reg == ST_COMP)
        else $error("compression start did not enter the round loop");

    a_emit_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("digest word emitted into an occupied output register");

    a_rearm_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rearm |-> (cmd.emit && cmd.emit_idx == 3'd7))
        else $error("re-arm without the final digest word");

endmodule

FILE: rtl/smh_datapath.sv
// Block buffer, message schedule, round function, chaining value and output register.
module smh_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  smh_pkg::in_item_t   s_data,
    input  smh_pkg::dp_cmd_t    cmd,
    output smh_pkg::dp_status_t status,
    output logic                m_valid,
    input  logic                m_ready,
    output smh_pkg::out_item_t  m_data
);

    localparam int unsigned RCNT_W = $clog2(smh_pkg::ROUNDS + 1);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [15:0][31:0] win_reg;
    logic [0:7][31:0]  var_reg, var_next;
    logic [0:7][31:0]  chain_reg;
    logic [3:0]        pos_reg;
    logic [smh_pkg::LEN_W-1:0] bytes_reg;
    logic [RCNT_W-1:0] rcnt_reg;
    logic [31:0]       held_word_reg;
    logic [2:0]        held_cnt_reg;
    logic              m_valid_reg;
    smh_pkg::out_item_t m_data_reg;

    logic [2:0]  in_cnt;
    logic [31:0] pad_word, push_word, sched_word;
    logic [31:0] s0, s1, big0, big1, ch, maj, t1, t2, k_word;

    // Count clamped to four; a word that is not last always counts four bytes.
    always_comb begin
        if (!s_data.last_item || s_data.valid_bytes > 3'd4) begin
            in_cnt = 3'd4;
        end else begin
            in_cnt = s_data.valid_bytes;
        end
    end

    always_comb begin
        case (held_cnt_reg)
            3'd1:    pad_word = {held_word_reg[31:24], 8'h80, 16'h0000};
            3'd2:    pad_word = {held_word_reg[31:16], 8'h80, 8'h00};
            3'd3:    pad_word = {held_word_reg[31:8], 8'h80};
            default: pad_word = 32'h8000_0000;
        endcase
    end

    always_comb begin
        case (cmd.src)
            smh_pkg::SRC_INPUT:  push_word = s_data.msg_word;
            smh_pkg::SRC_HELD:   push_word = held_word_reg;
            smh_pkg::SRC_PAD:    push_word = pad_word;
            smh_pkg::SRC_LEN_HI: push_word = bytes_reg[60:29];
            smh_pkg::SRC_LEN_LO: push_word = {bytes_reg[28:0], 3'b000};
            default:             push_word = 32'h0000_0000;
        endcase
    end

    // Schedule: window slot 0 is W[t]; produce W[t+16].
    always_comb begin
        s0 = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
        s1 = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
        sched_word = s1 + win_reg[9] + s0 + win_reg[0];
    end

    always_comb begin
        k_word = smh_pkg::K_TABLE[rcnt_reg[5:0]];
        big1 = rotr(var_reg[4], 6) ^ rotr(var_reg[4], 11) ^ rotr(var_reg[4], 25);
        ch   = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        t1   = var_reg[7] + big1 + ch + k_word + win_reg[0];
        big0 = rotr(var_reg[0], 2) ^ rotr(var_reg[0], 13) ^ rotr(var_reg[0], 22);
        maj  = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
             ^ (var_reg[1] & var_reg[2]);
        t2   = big0 + maj;
        var_next[7] = var_reg[6];
        var_next[6] = var_reg[5];
        var_next[5] = var_reg[4];
        var_next[4] = var_reg[3] + t1;
        var_next[3] = var_reg[2];
        var_next[2] = var_reg[1];
        var_next[1] = var_reg[0];
        var_next[0] = t1 + t2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg   <= smh_pkg::IV;
            pos_reg     <= 4'd0;
            bytes_reg   <= '0;
            rcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                bytes_reg <= bytes_reg + {{(smh_pkg::LEN_W-3){1'b0}}, in_cnt};
            end
            if (cmd.push) begin
                pos_reg <= pos_reg + 4'd1;
            end
            if (cmd.comp_init) begin
                rcnt_reg <= '0;
            end else if (cmd.round) begin
                rcnt_reg <= rcnt_reg + RCNT_W'(1);
            end
            if (cmd.finalize) begin
                for (int i = 0; i < 8; i++) begin
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
                end
            end
            if (cmd.rearm) begin
                chain_reg <= smh_pkg::IV;
                bytes_reg <= '0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            held_word_reg <= s_data.msg_word;
            held_cnt_reg  <= in_cnt;
        end
        if (cmd.push) begin
            win_reg <= {push_word, win_reg[15:1]};
        end else if (cmd.round) begin
            win_reg <= {sched_word, win_reg[15:1]};
        end
        if (cmd.comp_init) begin
            var_reg <= chain_reg;
        end else if (cmd.round) begin
            var_reg <= var_next;
        end
        if (cmd.emit) begin
            m_data_reg.digest_word  <= chain_reg[cmd.emit_idx];
            m_data_reg.digest_index <= cmd.emit_idx;
            m_data_reg.digest_last  <= (cmd.emit_idx == 3'd7);
        end
    end

    assign status.pos_last   = (pos_reg == 4'd15);
    assign status.pos_len    = (pos_reg == 4'd14);
    assign status.round_done = (rcnt_reg == RCNT_W'(smh_pkg::ROUNDS));
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_init_at_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.comp_init |-> (cmd.push && pos_reg == 4'd15))
        else $error("compression started on a partial block");

    a_finalize_after_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finalize |-> rcnt_reg == RCNT_W'(smh_pkg::ROUNDS))
        else $error("chaining value updated before all rounds ran");

    a_no_push_in_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.round |-> (!cmd.push && !cmd.accept && rcnt_reg < RCNT_W'(smh_pkg::ROUNDS)))
        else $error("buffer disturbed during compression");

endmodule

FILE: rtl/sha256_message_hasher.sv
// Top level of the SHA-256 message hasher: controller plus datapath.
//
// Streams a message in as 32-bit big-endian words (first byte in bits 31..24),
// each s_ transaction carrying a valid-byte count and a last flag; only the
// last transaction may carry fewer than four bytes, and a last transaction
// with zero bytes ends an empty message. A word that is not last always counts
// as four bytes, and a count above four is taken as four. Each word that is
// not last is pushed into the block buffer as it is accepted; each full
// 64-byte block then runs through the compression unit (64 rounds, one per
// cycle, plus a final step to fold the working variables into the chaining
// value), and no input is taken while it runs, so that single round unit
// sets the pace of a long message. On the last word the padding sequencer
// adds the marker byte, zeros and the 64-bit bit length, and runs one or two
// more compressions. The eight digest words then leave on the m_ channel,
// index 0 first, one per cycle when m_ready stays high, the eighth marked
// digest_last. The block re-arms with the initial hash values as the eighth
// word enters the output register and takes the next message while that word
// still waits. The block buffer is a 16-word shift window with no reset;
// after reset nothing needs clearing.
module sha256_message_hasher (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  smh_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output smh_pkg::out_item_t m_data
);

    // Commands from the sequencer and status back from the datapath.
    smh_pkg::dp_cmd_t    cmd;
    smh_pkg::dp_status_t status;

    // Sequencer: owns s_ready, the padding order and the digest word index.
    smh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_data  (s_data),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: hold the buffer window, byte count, round state and output register.
    smh_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
